// ----- rtl/core/fla_pkg.sv -----
// Package for the free-list block allocator.
// Holds the controller state type, request, status, policy and
// config codes, and the datapath command and status structs.
package fla_pkg;

    localparam int SIZE_W = 11;
    localparam int POL_W  = 2;

    typedef enum logic [0:0] {
        REQ_ALLOC   = 1'b0,
        REQ_RELEASE = 1'b1
    } req_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOFIT   = 2'd1,
        ST_FULL    = 2'd2,
        ST_ZERO    = 2'd3
    } status_t;

    localparam logic [POL_W-1:0] POL_FIRST = 2'd0;
    localparam logic [POL_W-1:0] POL_BEST  = 2'd1;
    localparam logic [POL_W-1:0] POL_WORST = 2'd2;

    localparam logic [1:0] CFG_POLICY = 2'd0;
    localparam logic [1:0] CFG_TOTAL  = 2'd1;
    localparam logic [1:0] CFG_MINFR  = 2'd2;

    localparam logic [SIZE_W-1:0] MEM_LIMIT      = 11'd1024;
    localparam logic [SIZE_W-1:0] MIN_FRAG_RESET = 11'd10;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_SCAN,
        S_UPDATE,
        S_OUT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic init_clear;  // one entry of the table cleared per cycle
        logic load;        // latch a request
        logic scan_start;  // reset scan index and scan results
        logic scan_step;   // examine one entry
        logic update;      // commit the request
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic init_last;
        logic scan_last;
    } stat_t;

endpackage

// ----- rtl/core/fla_datapath.sv -----
// Datapath for the free-list block allocator: region table, scan unit,
// update logic and result register. Depends on fla_pkg.
module fla_datapath
    import fla_pkg::*;
#(
    parameter int FREE_SLOTS = 16,
    parameter int ADDR_BITS  = 10
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  cmd_t                   cmd,
    output stat_t                  stat,
    input  logic                   cfg_we,
    input  logic [1:0]             cfg_index,
    input  logic [SIZE_W-1:0]      cfg_data,
    input  logic                   in_type,
    input  logic [SIZE_W-1:0]      in_size,
    input  logic [ADDR_BITS-1:0]   in_start,
    output logic [1:0]             res_status,
    output logic [ADDR_BITS-1:0]   res_start,
    output logic [SIZE_W-1:0]      res_size,
    output logic [$clog2(FREE_SLOTS+1)-1:0] res_count
);

    localparam int IDX_W = $clog2(FREE_SLOTS);
    localparam int CNT_W = $clog2(FREE_SLOTS+1);
    // one extra bit: a split can leave an empty region at the top address
    localparam int BW    = ADDR_BITS + 1;
    // wide enough for addresses, sizes and their sums
    localparam int AW    = (ADDR_BITS > SIZE_W ? ADDR_BITS : SIZE_W) + 1;
    localparam logic [AW-1:0] CAP_RAW = (ADDR_BITS < SIZE_W) ? AW'(1 << ADDR_BITS)
                                                             : AW'(MEM_LIMIT);
    localparam logic [AW-1:0] CAP = (CAP_RAW < AW'(MEM_LIMIT)) ? CAP_RAW : AW'(MEM_LIMIT);

    logic [POL_W-1:0]  policy_reg;
    logic [SIZE_W-1:0] total_reg;
    logic [SIZE_W-1:0] minfr_reg;

    logic [BW-1:0]        base_reg [FREE_SLOTS];
    logic [SIZE_W-1:0]    len_reg  [FREE_SLOTS];
    logic [FREE_SLOTS-1:0] valid_reg;
    logic [CNT_W-1:0]     count_reg;

    logic                 type_reg;
    logic [SIZE_W-1:0]    size_reg;
    logic [ADDR_BITS-1:0] start_reg;

    logic [IDX_W-1:0] idx_reg;
    logic             pick_ok_reg, left_ok_reg, right_ok_reg, free_ok_reg, ovl_reg;
    logic [IDX_W-1:0] pick_reg, left_reg, right_reg, free_reg;

    // ---- configuration ----
    logic [AW-1:0] cfg_total;
    always_comb
    begin
        cfg_total = AW'(cfg_data);
        if (cfg_total == '0) cfg_total = AW'(1);
        if (cfg_total > CAP) cfg_total = CAP;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= POL_FIRST;
            total_reg  <= SIZE_W'(CAP);
            minfr_reg  <= MIN_FRAG_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_POLICY: policy_reg <= cfg_data[POL_W-1:0];
                CFG_TOTAL:  total_reg  <= SIZE_W'(cfg_total);
                CFG_MINFR:  minfr_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---- scan of the current entry ----
    logic [BW-1:0]        cur_b, pk_b;
    logic [SIZE_W-1:0]    cur_l, pk_l;
    logic [AW-1:0]        cur_e, req_end;
    logic                 cur_v, fits, better, lower;

    always_comb
    begin
        cur_b   = base_reg[idx_reg];
        cur_l   = len_reg[idx_reg];
        cur_v   = valid_reg[idx_reg];
        pk_b    = base_reg[pick_reg];
        pk_l    = len_reg[pick_reg];
        cur_e   = AW'(cur_b) + AW'(cur_l);
        req_end = AW'(start_reg) + AW'(size_reg);
        fits    = cur_v && (cur_l >= size_reg);
        lower   = cur_b < pk_b;
        case (policy_reg)
            POL_BEST:  better = (cur_l < pk_l) || ((cur_l == pk_l) && lower);
            POL_WORST: better = (cur_l > pk_l) || ((cur_l == pk_l) && lower);
            default:   better = lower;
        endcase
    end

    assign stat.scan_last = (idx_reg == IDX_W'(FREE_SLOTS-1));
    assign stat.init_last = (idx_reg == IDX_W'(FREE_SLOTS-1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg     <= '0;
            pick_ok_reg <= 1'b0;
            left_ok_reg <= 1'b0;
            right_ok_reg<= 1'b0;
            free_ok_reg <= 1'b0;
            ovl_reg     <= 1'b0;
            pick_reg    <= '0;
            left_reg    <= '0;
            right_reg   <= '0;
            free_reg    <= '0;
        end
        else if (cmd.scan_start || cmd.load)
        begin
            idx_reg     <= '0;
            pick_ok_reg <= 1'b0;
            left_ok_reg <= 1'b0;
            right_ok_reg<= 1'b0;
            free_ok_reg <= 1'b0;
            ovl_reg     <= 1'b0;
            pick_reg    <= '0;
        end
        else if (cmd.init_clear)
        begin
            idx_reg <= idx_reg + IDX_W'(1);
        end
        else if (cmd.scan_step)
        begin
            idx_reg <= idx_reg + IDX_W'(1);
            if (fits && (!pick_ok_reg || better))
            begin
                pick_ok_reg <= 1'b1;
                pick_reg    <= idx_reg;
            end
            if (!cur_v)
            begin
                if (!free_ok_reg)
                begin
                    free_ok_reg <= 1'b1;
                    free_reg    <= idx_reg;
                end
            end
            else
            begin
                if ((AW'(start_reg) < cur_e) && (AW'(cur_b) < req_end)) ovl_reg <= 1'b1;
                if (cur_e == AW'(start_reg))
                begin
                    left_ok_reg <= 1'b1;
                    left_reg    <= idx_reg;
                end
                if (AW'(cur_b) == req_end)
                begin
                    right_ok_reg <= 1'b1;
                    right_reg    <= idx_reg;
                end
            end
        end
    end

    // ---- request latch ----
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            type_reg  <= in_type;
            size_reg  <= in_size;
            start_reg <= in_start;
        end
    end

    // ---- table and result update ----
    logic [SIZE_W-1:0] pk_rem;
    assign pk_rem = pk_l - size_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= FREE_SLOTS'(1);
            count_reg  <= CNT_W'(1);
            res_status <= ST_OK;
            res_start  <= '0;
            res_size   <= '0;
            res_count  <= '0;
            for (int i = 0; i < FREE_SLOTS; i++)
            begin
                base_reg[i] <= '0;
                len_reg[i]  <= '0;
            end
            len_reg[0] <= SIZE_W'(CAP);
        end
        else if (cfg_we && cfg_index == CFG_TOTAL)
        begin
            valid_reg   <= FREE_SLOTS'(1);
            count_reg   <= CNT_W'(1);
            base_reg[0] <= '0;
            len_reg[0]  <= SIZE_W'(cfg_total);
        end
        else if (cmd.init_clear)
        begin
            // entries above zero are cleared one per cycle after a size write
            if (idx_reg != '0)
            begin
                base_reg[idx_reg] <= '0;
                len_reg[idx_reg]  <= '0;
            end
        end
        else if (cmd.update)
        begin
            res_start <= '0;
            res_size  <= '0;
            res_count <= count_reg;
            if (size_reg == '0)
                res_status <= ST_ZERO;
            else if (type_reg == REQ_ALLOC)
            begin
                if (!pick_ok_reg)
                    res_status <= ST_NOFIT;
                else
                begin
                    res_status <= ST_OK;
                    res_start  <= ADDR_BITS'(pk_b);
                    if (pk_rem >= minfr_reg)
                    begin
                        res_size           <= size_reg;
                        base_reg[pick_reg] <= pk_b + BW'(size_reg);
                        len_reg[pick_reg]  <= pk_rem;
                    end
                    else
                    begin
                        res_size            <= pk_l;
                        valid_reg[pick_reg] <= 1'b0;
                        base_reg[pick_reg]  <= '0;
                        len_reg[pick_reg]   <= '0;
                        count_reg           <= count_reg - CNT_W'(1);
                        res_count           <= count_reg - CNT_W'(1);
                    end
                end
            end
            else
            begin
                if ((req_end > AW'(total_reg)) || ovl_reg)
                    res_status <= ST_NOFIT;
                else if (left_ok_reg && right_ok_reg)
                begin
                    res_status           <= ST_OK;
                    len_reg[left_reg]    <= len_reg[left_reg] + size_reg + len_reg[right_reg];
                    valid_reg[right_reg] <= 1'b0;
                    base_reg[right_reg]  <= '0;
                    len_reg[right_reg]   <= '0;
                    count_reg            <= count_reg - CNT_W'(1);
                    res_count            <= count_reg - CNT_W'(1);
                end
                else if (left_ok_reg)
                begin
                    res_status        <= ST_OK;
                    len_reg[left_reg] <= len_reg[left_reg] + size_reg;
                end
                else if (right_ok_reg)
                begin
                    res_status          <= ST_OK;
                    base_reg[right_reg] <= BW'(start_reg);
                    len_reg[right_reg]  <= len_reg[right_reg] + size_reg;
                end
                else if (!free_ok_reg)
                    res_status <= ST_FULL;
                else
                begin
                    res_status          <= ST_OK;
                    base_reg[free_reg]  <= BW'(start_reg);
                    len_reg[free_reg]   <= size_reg;
                    valid_reg[free_reg] <= 1'b1;
                    count_reg           <= count_reg + CNT_W'(1);
                    res_count           <= count_reg + CNT_W'(1);
                end
            end
        end
    end

endmodule

// ----- rtl/core/fla_ctrl.sv -----
// Controller state machine for the free-list block allocator.
// Sequences clear, scan, update and result handshake. Depends on fla_pkg.
module fla_ctrl
    import fla_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  cfg_total_we,
    input  stat_t stat,
    input  logic  in_fire,
    input  logic  out_fire,
    output logic  in_ready,
    output logic  out_valid,
    output cmd_t  cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) state_reg <= S_IDLE;
        else        state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (cfg_total_we) state_next = S_INIT;
                      else if (in_fire) state_next = S_SCAN;
            S_INIT:   if (stat.init_last) state_next = S_IDLE;
            S_SCAN:   if (stat.scan_last) state_next = S_UPDATE;
            S_UPDATE: state_next = S_OUT;
            S_OUT:    if (out_fire) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready       = !cfg_total_we;
                cmd.load       = in_fire;
                cmd.scan_start = cfg_total_we;
            end
            S_INIT:   cmd.init_clear = 1'b1;
            S_SCAN:   cmd.scan_step  = 1'b1;
            S_UPDATE: cmd.update     = 1'b1;
            S_OUT:    out_valid      = 1'b1;
            default: ;
        endcase
    end

endmodule

// ----- rtl/core/free_list_block_allocator.sv -----
// Free-list block allocator, top level: first, best or worst fit over a
// table of free regions. Each accepted beat scans every table entry in
// turn, then an update writes the table and the result beat.
// One item in flight: no beat is taken until the result beat is taken.
// Asynchronous active-low reset: one free region [0, 1024). A total_size write
// made while idle starts a table clear during which no beat is taken.
module free_list_block_allocator
    import fla_pkg::*;
#(
    parameter int FREE_SLOTS = 16,
    parameter int ADDR_BITS  = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // block_size[10:0], block_start[20:11]
    input  logic        s_axis_tuser,   // req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // status[1:0], grant_start, grant_size,
                                        // free_regions
);

    localparam int CNT_W = $clog2(FREE_SLOTS+1);

    cmd_t  cmd;
    stat_t stat;
    logic [1:0]           st;
    logic [ADDR_BITS-1:0] gs;
    logic [SIZE_W-1:0]    gz;
    logic [CNT_W-1:0]     cnt;

    fla_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_total_we (cfg_we && cfg_index == CFG_TOTAL),
        .stat         (stat),
        .in_fire      (s_axis_tvalid && s_axis_tready),
        .out_fire     (m_axis_tvalid && m_axis_tready),
        .in_ready     (s_axis_tready),
        .out_valid    (m_axis_tvalid),
        .cmd          (cmd)
    );

    fla_datapath #(
        .FREE_SLOTS (FREE_SLOTS),
        .ADDR_BITS  (ADDR_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_type    (s_axis_tuser),
        .in_size    (s_axis_tdata[10:0]),
        .in_start   (ADDR_BITS'(s_axis_tdata[20:11])),
        .res_status (st),
        .res_start  (gs),
        .res_size   (gz),
        .res_count  (cnt)
    );

    assign m_axis_tdata = {4'd0, 5'(cnt), gz, 10'(gs), st};

endmodule

// ----- rtl/core/fla_checker.sv -----
// Port-level checker for the free-list block allocator, with its bind.
// Depends on fla_pkg.
module fla_checker
    import fla_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);

    // one item in flight: no beat is taken while a result waits
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input taken while result pending");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped or changed");

    // a failed item, allocate or release, grants nothing
    a_zero_grant: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[1:0] != ST_OK |-> m_axis_tdata[22:2] == '0)
        else $error("grant on failed item");

    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid)
        else $error("result too early");

endmodule

bind free_list_block_allocator fla_checker u_fla_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
